[src/differential_motor_pid_controller_assert.svh]
// Assertion macros for the differential motor PID controller.
`ifndef DIFFERENTIAL_MOTOR_PID_CONTROLLER_ASSERT_SVH
`define DIFFERENTIAL_MOTOR_PID_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define DMPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A consequence that must hold at the clock edge after its trigger.
`define DMPC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`else
`define DMPC_ASSERT(label, prop, msg)
`define DMPC_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

[src/dmpc_pkg.sv]
// Shared types and constants of the differential motor PID controller.
package dmpc_pkg;

  // Pipeline depth, input register through result register.
  localparam int unsigned NumStages = 7;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgKp         = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKi         = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKd         = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWsadSpeed  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDriveLimit = 3'd5;

  localparam logic [7:0]  KpReset         = 8'd2;
  localparam logic [7:0]  KiReset         = 8'd1;
  localparam logic [7:0]  KdReset         = 8'd5;
  localparam logic [11:0] MaxSpeedReset   = 12'd3000;
  localparam logic [11:0] WsadSpeedReset  = 12'd2000;
  localparam logic [15:0] DriveLimitReset = 16'd65535;

  // Command frame kinds and key characters.
  localparam logic [7:0] FrameEnable = 8'h21;
  localparam logic [7:0] FrameProp   = 8'h3F;
  localparam logic [7:0] FrameKey    = 8'h40;
  localparam logic [7:0] KeyW        = 8'h77;
  localparam logic [7:0] KeyS        = 8'h73;
  localparam logic [7:0] KeyA        = 8'h61;
  localparam logic [7:0] KeyD        = 8'h64;

  // Proportional byte handling: clamp, midpoint and full-scale step count.
  localparam logic [7:0] PropClamp = 8'd200;
  localparam logic [7:0] PropMid   = 8'd100;
  localparam logic [6:0] FullScale = 7'd100;

  // floor(x / 100) for x below 2**19 as (x * ScaleRecip) >> ScaleShift.
  localparam logic [19:0] ScaleRecip = 20'd671089;
  localparam int unsigned ScaleShift = 26;

  // floor(x / 125) for x below 2**36 as (x * IntRecip) >> IntShift, split in halves.
  localparam logic [36:0] IntRecip    = 37'd70368744178;
  localparam int unsigned IntRecipLoW = 19;
  localparam int unsigned IntXLoW     = 18;
  localparam logic [18:0] IntRecipLo  = IntRecip[18:0];
  localparam logic [17:0] IntRecipHi  = IntRecip[36:19];
  localparam int unsigned IntShift    = 43;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ENABLE,
    CMD_TARGET,
    CMD_STOP
  } dmpc_cmd_e;

  // Stage strobes that the top level hands to each motor lane.
  typedef struct packed {
    logic upd_state;
    logic ld_prod;
    logic ld_part;
    logic ld_integ;
    logic upd_drive;
  } dmpc_lane_ctl_t;

  // Per-beat status carried down the pipeline next to the lanes.
  typedef struct packed {
    logic is_tick;
    logic fwd_l;
    logic fwd_r;
    logic en;
    logic kick;
  } dmpc_status_t;

endpackage

[src/differential_motor_pid_controller.sv]
// Top level of the two-motor PID speed controller with its command decoder.
//
// Input beats carry either a command frame (action 0) or a control tick with
// both measured speeds (action 1); every input beat yields exactly one result
// beat. Both data channels use valid and stall: a beat moves at a clock edge
// with valid high and stall low. The configuration channel (index, data) is
// always ready and must only be written while no beats are in flight.
// One beat per cycle is sustained while the result side does not stall.
// The rate is set by the error-sum and target update, a loop closed in
// stage two; the gain products, the divide of the integral term by 1000
// and the saturation follow in stages. A stalled result holds in the output
// register while the stages behind it keep accepting until the pipeline is
// full, seven beats deep. Reset restores the default gains and limits, clears
// targets, error sums, directions, the enable flag and the held drives, and
// empties the pipeline.
`include "differential_motor_pid_controller_assert.svh"
module differential_motor_pid_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [7:0]                     frame_kind_i,
  input  logic [7:0]                     arg_a_i,
  input  logic [7:0]                     arg_b_i,
  input  logic signed [15:0]             measured_left_i,
  input  logic signed [15:0]             measured_right_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [16:0]             drive_left_o,
  output logic signed [16:0]             drive_right_o,
  output logic                           forward_left_o,
  output logic                           forward_right_o,
  output logic                           motors_enabled_o,
  output logic                           watchdog_kick_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dmpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dmpc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dmpc_pkg::*;

  // Configuration registers.
  logic [7:0]  kp_q;
  logic [7:0]  ki_q;
  logic [7:0]  kd_q;
  logic [11:0] top_speed_q;
  logic [11:0] wsad_speed_q;
  logic [15:0] drive_limit_q;

  // Pipeline control.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] ld;

  // Stage zero: input register.
  logic               r0_action_q;
  logic [7:0]         r0_kind_q;
  logic [7:0]         r0_arg_a_q;
  logic [7:0]         r0_arg_b_q;
  logic signed [15:0] r0_meas_l_q;
  logic signed [15:0] r0_meas_r_q;

  // Stage one: decoded command.
  logic               r1_tick_q;
  dmpc_cmd_e          r1_cmd_q;
  logic               r1_en_arg_q;
  logic [18:0]        r1_prod_l_q;
  logic [18:0]        r1_prod_r_q;
  logic               r1_neg_l_q;
  logic               r1_neg_r_q;
  logic signed [15:0] r1_meas_l_q;
  logic signed [15:0] r1_meas_r_q;

  dmpc_cmd_e   cmd_d;
  logic [11:0] opnd;
  logic [6:0]  mult_l;
  logic [6:0]  mult_r;
  logic        neg_l;
  logic        neg_r;
  logic [7:0]  pm_l;
  logic [7:0]  pm_r;

  // Controller state.
  logic signed [12:0] tgt_l_q;
  logic signed [12:0] tgt_r_q;
  logic [1:0]         dir_q;
  logic               en_q;

  logic signed [12:0] tgt_l_d;
  logic signed [12:0] tgt_r_d;
  logic [1:0]         dir_d;
  logic               en_d;
  logic               kick_d;

  logic [38:0]        sp_l;
  logic [38:0]        sp_r;
  logic [11:0]        sq_l;
  logic [11:0]        sq_r;
  logic signed [12:0] stgt_l;
  logic signed [12:0] stgt_r;

  dmpc_status_t   st_q [2:NumStages-1];
  dmpc_lane_ctl_t lane_ctl;

  // Magnitude and sign of a proportional byte after clamping, relative to mid.
  function automatic logic [7:0] prop_mag(input logic [7:0] b);
    logic [7:0] c;
    c = (b > PropClamp) ? PropClamp : b;
    if (c < PropMid) begin
      return {1'b1, 7'(PropMid - c)};
    end else begin
      return {1'b0, 7'(c - PropMid)};
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q          <= KpReset;
      ki_q          <= KiReset;
      kd_q          <= KdReset;
      top_speed_q   <= MaxSpeedReset;
      wsad_speed_q  <= WsadSpeedReset;
      drive_limit_q <= DriveLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKp:         kp_q          <= cfg_data_i[7:0];
        CfgKi:         ki_q          <= cfg_data_i[7:0];
        CfgKd:         kd_q          <= cfg_data_i[7:0];
        CfgMaxSpeed:   top_speed_q   <= cfg_data_i[11:0];
        CfgWsadSpeed:  wsad_speed_q  <= cfg_data_i[11:0];
        CfgDriveLimit: drive_limit_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // A stage takes a beat when it is empty or its own beat moves on.
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = in_valid_i && rdy[0];
    for (int k = 1; k < NumStages; k++) begin
      ld[k] = vld_q[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= ld[k];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // Command decode: each side's target is operand * multiplier / 100.
  always_comb begin
    cmd_d  = CMD_NONE;
    opnd   = top_speed_q;
    mult_l = '0;
    mult_r = '0;
    neg_l  = 1'b0;
    neg_r  = 1'b0;
    pm_l   = prop_mag(r0_arg_a_q);
    pm_r   = prop_mag(r0_arg_b_q);
    if (!r0_action_q) begin
      unique case (r0_kind_q)
        FrameEnable: cmd_d = CMD_ENABLE;
        FrameProp: begin
          cmd_d  = CMD_TARGET;
          neg_l  = pm_l[7];
          mult_l = pm_l[6:0];
          neg_r  = pm_r[7];
          mult_r = pm_r[6:0];
        end
        FrameKey: begin
          opnd   = wsad_speed_q;
          mult_l = FullScale;
          mult_r = FullScale;
          cmd_d  = CMD_TARGET;
          unique case (r0_arg_a_q)
            KeyW: begin
              neg_l = 1'b0;
              neg_r = 1'b0;
            end
            KeyS: begin
              neg_l = 1'b1;
              neg_r = 1'b1;
            end
            KeyA: begin
              neg_l = 1'b1;
              neg_r = 1'b0;
            end
            KeyD: begin
              neg_l = 1'b0;
              neg_r = 1'b1;
            end
            default: cmd_d = CMD_STOP;
          endcase
        end
        default: cmd_d = CMD_NONE;
      endcase
    end
  end

  // Target scaling, state update and result status for stage two.
  always_comb begin
    sp_l   = 39'(r1_prod_l_q) * 39'(ScaleRecip);
    sp_r   = 39'(r1_prod_r_q) * 39'(ScaleRecip);
    sq_l   = sp_l[ScaleShift+11:ScaleShift];
    sq_r   = sp_r[ScaleShift+11:ScaleShift];
    stgt_l = r1_neg_l_q ? (13'sd0 - $signed({1'b0, sq_l})) : $signed({1'b0, sq_l});
    stgt_r = r1_neg_r_q ? (13'sd0 - $signed({1'b0, sq_r})) : $signed({1'b0, sq_r});

    tgt_l_d = tgt_l_q;
    tgt_r_d = tgt_r_q;
    dir_d   = dir_q;
    en_d    = en_q;
    kick_d  = 1'b0;
    if (!r1_tick_q) begin
      unique case (r1_cmd_q)
        CMD_ENABLE: en_d = r1_en_arg_q;
        CMD_TARGET: begin
          tgt_l_d = stgt_l;
          tgt_r_d = stgt_r;
          // A target that truncates to zero counts as forward.
          dir_d   = {!(r1_neg_r_q && (sq_r != '0)), !(r1_neg_l_q && (sq_l != '0))};
          kick_d  = 1'b1;
        end
        CMD_STOP: begin
          tgt_l_d = '0;
          tgt_r_d = '0;
        end
        CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_l_q <= '0;
      tgt_r_q <= '0;
      dir_q   <= '0;
      en_q    <= 1'b0;
    end else if (ld[2]) begin
      tgt_l_q <= tgt_l_d;
      tgt_r_q <= tgt_r_d;
      dir_q   <= dir_d;
      en_q    <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      r0_action_q <= action_i;
      r0_kind_q   <= frame_kind_i;
      r0_arg_a_q  <= arg_a_i;
      r0_arg_b_q  <= arg_b_i;
      r0_meas_l_q <= measured_left_i;
      r0_meas_r_q <= measured_right_i;
    end
    if (ld[1]) begin
      r1_tick_q   <= r0_action_q;
      r1_cmd_q    <= cmd_d;
      r1_en_arg_q <= (r0_arg_a_q != '0);
      r1_prod_l_q <= 19'(opnd) * 19'(mult_l);
      r1_prod_r_q <= 19'(opnd) * 19'(mult_r);
      r1_neg_l_q  <= neg_l;
      r1_neg_r_q  <= neg_r;
      r1_meas_l_q <= r0_meas_l_q;
      r1_meas_r_q <= r0_meas_r_q;
    end
    if (ld[2]) begin
      st_q[2] <= '{is_tick: r1_tick_q, fwd_l: dir_d[0], fwd_r: dir_d[1], en: en_d,
                   kick: kick_d};
    end
    for (int k = 3; k < NumStages; k++) begin
      if (ld[k]) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  always_comb begin
    lane_ctl.upd_state = ld[2] && r1_tick_q;
    lane_ctl.ld_prod   = ld[3];
    lane_ctl.ld_part   = ld[4];
    lane_ctl.ld_integ  = ld[5];
    lane_ctl.upd_drive = ld[6] && st_q[5].is_tick;
  end

  dmpc_pid_lane u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .kp_i       (kp_q),
    .ki_i       (ki_q),
    .kd_i       (kd_q),
    .limit_i    (drive_limit_q),
    .target_i   (tgt_l_q),
    .measured_i (r1_meas_l_q),
    .drive_o    (drive_left_o)
  );

  dmpc_pid_lane u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lane_ctl),
    .kp_i       (kp_q),
    .ki_i       (ki_q),
    .kd_i       (kd_q),
    .limit_i    (drive_limit_q),
    .target_i   (tgt_r_q),
    .measured_i (r1_meas_r_q),
    .drive_o    (drive_right_o)
  );

  assign out_valid_o      = vld_q[NumStages-1];
  assign forward_left_o   = st_q[NumStages-1].fwd_l;
  assign forward_right_o  = st_q[NumStages-1].fwd_r;
  assign motors_enabled_o = st_q[NumStages-1].en;
  assign watchdog_kick_o  = st_q[NumStages-1].kick;

  `DMPC_ASSERT(a_kick_on_command,
               (out_valid_o && watchdog_kick_o) |-> !st_q[6].is_tick,
               "kick on a tick result")
  `DMPC_ASSERT(a_drive_in_limit,
               (out_valid_o && st_q[6].is_tick) |->
                 (($signed(drive_left_o) <= $signed({1'b0, drive_limit_q})) &&
                  ($signed(drive_left_o) >= -$signed({1'b0, drive_limit_q}))),
               "left drive beyond limit")
  `DMPC_ASSERT(a_empty_out_no_stall, !out_valid_o |-> !in_stall_o,
               "input stalled with empty output")
  `DMPC_ASSERT_NEXT(a_cmd_drive_hold, ld[6] && !st_q[5].is_tick,
                    $stable(drive_left_o) && $stable(drive_right_o),
                    "command beat changed the drives")

endmodule

[src/dmpc_pid_lane.sv]
// PID datapath of one motor: error state, gain products, integral divide and saturation.
module dmpc_pid_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmpc_pkg::dmpc_lane_ctl_t ctl_i,
  input  logic [7:0]              kp_i,
  input  logic [7:0]              ki_i,
  input  logic [7:0]              kd_i,
  input  logic [15:0]             limit_i,
  input  logic signed [12:0]      target_i,
  input  logic signed [15:0]      measured_i,
  output logic signed [16:0]      drive_o
);
  import dmpc_pkg::*;

  logic signed [31:0] err_sum_q;
  logic signed [16:0] last_err_q;
  logic signed [16:0] drive_q;

  logic signed [16:0] err_d;
  logic signed [17:0] derr_d;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_d;

  logic signed [16:0] err_q;
  logic signed [17:0] derr_q;
  logic signed [31:0] sum_q;

  logic [31:0]        sum_mag;
  logic signed [25:0] pe_d;
  logic signed [26:0] pd_d;
  logic [39:0]        pi_d;

  logic signed [25:0] pe3_q;
  logic signed [26:0] pd3_q;
  logic [39:0]        pi3_q;
  logic               sneg3_q;

  logic [35:0] x_div;
  logic [17:0] x_lo;
  logic [17:0] x_hi;

  logic [36:0]        pll_q;
  logic [35:0]        plh_q;
  logic [36:0]        phl_q;
  logic [35:0]        phh_q;
  logic signed [25:0] pe4_q;
  logic signed [26:0] pd4_q;
  logic               sneg4_q;

  logic [73:0]        quo_wide;
  logic [29:0]        quo;
  logic signed [30:0] integ_d;

  logic signed [30:0] integ5_q;
  logic signed [25:0] pe5_q;
  logic signed [26:0] pd5_q;

  logic signed [31:0] drive_sum;
  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;
  logic signed [16:0] drive_d;

  // Error, saturated error sum and error difference for the next tick.
  always_comb begin
    err_d    = $signed({{4{target_i[12]}}, target_i}) - $signed({measured_i[15], measured_i});
    sum_wide = $signed({err_sum_q[31], err_sum_q}) + $signed({{16{err_d[16]}}, err_d});
    if (sum_wide[32] != sum_wide[31]) begin
      sum_d = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_d = sum_wide[31:0];
    end
    derr_d = $signed({err_d[16], err_d}) - $signed({last_err_q[16], last_err_q});
  end

  // Gain products; the integral term works on the magnitude of the sum.
  always_comb begin
    sum_mag = sum_q[31] ? (~sum_q + 32'd1) : sum_q;
    pe_d    = $signed({1'b0, kp_i}) * err_q;
    pd_d    = $signed({1'b0, kd_i}) * derr_q;
    pi_d    = 40'(ki_i) * 40'(sum_mag);
  end

  // Dividing by 1000 is a shift by three and a reciprocal multiply for 125.
  assign x_div = pi3_q[38:3];
  assign x_lo  = x_div[IntXLoW-1:0];
  assign x_hi  = x_div[35:IntXLoW];

  always_comb begin
    quo_wide = 74'(pll_q)
             + (74'(plh_q) << IntRecipLoW)
             + (74'(phl_q) << IntXLoW)
             + (74'(phh_q) << (IntRecipLoW + IntXLoW));
    quo      = quo_wide[IntShift+29:IntShift];
    integ_d  = sneg4_q ? (31'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
  end

  always_comb begin
    drive_sum = $signed({{6{pe5_q[25]}}, pe5_q})
              + $signed({{5{pd5_q[26]}}, pd5_q})
              + $signed({integ5_q[30], integ5_q});
    lim_pos   = $signed({16'd0, limit_i});
    lim_neg   = 32'sd0 - lim_pos;
    if (drive_sum > lim_pos) begin
      drive_d = lim_pos[16:0];
    end else if (drive_sum < lim_neg) begin
      drive_d = lim_neg[16:0];
    end else begin
      drive_d = drive_sum[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
      drive_q    <= '0;
    end else begin
      if (ctl_i.upd_state) begin
        err_sum_q  <= sum_d;
        last_err_q <= err_d;
      end
      if (ctl_i.upd_drive) begin
        drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_state) begin
      err_q  <= err_d;
      derr_q <= derr_d;
      sum_q  <= sum_d;
    end
    if (ctl_i.ld_prod) begin
      pe3_q   <= pe_d;
      pd3_q   <= pd_d;
      pi3_q   <= pi_d;
      sneg3_q <= sum_q[31];
    end
    if (ctl_i.ld_part) begin
      pll_q   <= 37'(x_lo) * 37'(IntRecipLo);
      plh_q   <= 36'(x_lo) * 36'(IntRecipHi);
      phl_q   <= 37'(x_hi) * 37'(IntRecipLo);
      phh_q   <= 36'(x_hi) * 36'(IntRecipHi);
      pe4_q   <= pe3_q;
      pd4_q   <= pd3_q;
      sneg4_q <= sneg3_q;
    end
    if (ctl_i.ld_integ) begin
      integ5_q <= integ_d;
      pe5_q    <= pe4_q;
      pd5_q    <= pd4_q;
    end
  end

  assign drive_o = drive_q;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the differential motor PID controller.
`timescale 1ns / 1ps
module tb_top;
  import dmpc_pkg::*;

  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -64'sd2147483648;
  localparam longint IntegDiv = 1000;
  localparam int unsigned IdlePct = 12;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldCycles = 80;
  // A short run of ticks at the largest error winds both error sums up, then down.
  localparam int unsigned WindUpTicks = 40;
  localparam int unsigned WindDownTicks = 40;

  typedef struct {
    logic              action;
    logic [7:0]        kind;
    logic [7:0]        arg_a;
    logic [7:0]        arg_b;
    logic signed [15:0] meas_l;
    logic signed [15:0] meas_r;
  } cmd_beat_t;

  typedef struct {
    logic signed [16:0] drive_left;
    logic signed [16:0] drive_right;
    logic               forward_left;
    logic               forward_right;
    logic               motors_enabled;
    logic               watchdog_kick;
  } drive_result_t;

  class drive_scoreboard;
    logic [7:0] kp, ki, kd;
    logic [11:0] top_speed, wsad_speed;
    logic [15:0] drive_limit;
    longint target_l, target_r, sum_l, sum_r, last_err_l, last_err_r, hold_l, hold_r;
    logic fwd_l, fwd_r, enabled;
    drive_result_t expected_q[$];
    int unsigned failures;

    function new();
      kp = KpReset;
      ki = KiReset;
      kd = KdReset;
      top_speed = MaxSpeedReset;
      wsad_speed = WsadSpeedReset;
      drive_limit = DriveLimitReset;
      target_l = 0;
      target_r = 0;
      sum_l = 0;
      sum_r = 0;
      last_err_l = 0;
      last_err_r = 0;
      hold_l = 0;
      hold_r = 0;
      fwd_l = 1'b0;
      fwd_r = 1'b0;
      enabled = 1'b0;
      failures = 0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgKp:         kp = val[7:0];
        CfgKi:         ki = val[7:0];
        CfgKd:         kd = val[7:0];
        CfgMaxSpeed:   top_speed = val[11:0];
        CfgWsadSpeed:  wsad_speed = val[11:0];
        CfgDriveLimit: drive_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Bytes above the clamp count as full scale; the divide truncates toward zero.
    function longint prop_target(logic [7:0] code);
      longint c;
      c = longint'(code);
      if (c > longint'(PropClamp)) c = longint'(PropClamp);
      return (longint'(top_speed) * (c - longint'(PropMid))) / longint'(FullScale);
    endfunction

    function void steer(longint l, longint r);
      target_l = l;
      target_r = r;
      fwd_l = (l >= 0);
      fwd_r = (r >= 0);
    endfunction

    function longint pid_lane(longint tgt, longint meas, inout longint sum,
                              inout longint last_err);
      longint e, s, d, lim;
      e = tgt - meas;
      s = sum + e;
      if (s > SumMax) s = SumMax;
      if (s < SumMin) s = SumMin;
      sum = s;
      d = longint'(kp) * e + (longint'(ki) * s) / IntegDiv + longint'(kd) * (e - last_err);
      last_err = e;
      lim = longint'(drive_limit);
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      return d;
    endfunction

    function void note_beat(cmd_beat_t b);
      drive_result_t r;
      longint w;
      w = longint'(wsad_speed);
      r.watchdog_kick = 1'b0;
      if (b.action) begin
        hold_l = pid_lane(target_l, longint'(b.meas_l), sum_l, last_err_l);
        hold_r = pid_lane(target_r, longint'(b.meas_r), sum_r, last_err_r);
      end else begin
        case (b.kind)
          FrameEnable: enabled = (b.arg_a != 8'd0);
          FrameProp: begin
            steer(prop_target(b.arg_a), prop_target(b.arg_b));
            r.watchdog_kick = 1'b1;
          end
          FrameKey: begin
            r.watchdog_kick = 1'b1;
            case (b.arg_a)
              KeyW: steer(w, w);
              KeyS: steer(-w, -w);
              KeyA: steer(-w, w);
              KeyD: steer(w, -w);
              default: begin
                // Any other key stops both motors but leaves the directions alone.
                target_l = 0;
                target_r = 0;
                r.watchdog_kick = 1'b0;
              end
            endcase
          end
          default: ;
        endcase
      end
      r.drive_left = hold_l[16:0];
      r.drive_right = hold_r[16:0];
      r.forward_left = fwd_l;
      r.forward_right = fwd_r;
      r.motors_enabled = enabled;
      expected_q.push_back(r);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected result beat: drive %0d %0d", got.drive_left, got.drive_right);
        return;
      end
      want = expected_q.pop_front();
      if (got.drive_left !== want.drive_left || got.drive_right !== want.drive_right ||
          got.forward_left !== want.forward_left ||
          got.forward_right !== want.forward_right ||
          got.motors_enabled !== want.motors_enabled ||
          got.watchdog_kick !== want.watchdog_kick) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("mismatch at %0t: drive_left exp %0d got %0d, drive_right exp %0d got %0d",
                   $realtime, want.drive_left, got.drive_left,
                   want.drive_right, got.drive_right);
          $display("  exp/got: fwd_l %b/%b fwd_r %b/%b en %b/%b kick %b/%b",
                   want.forward_left, got.forward_left, want.forward_right,
                   got.forward_right, want.motors_enabled, got.motors_enabled,
                   want.watchdog_kick, got.watchdog_kick);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i;
  logic in_stall_o;
  logic action_i;
  logic [7:0] frame_kind_i;
  logic [7:0] arg_a_i;
  logic [7:0] arg_b_i;
  logic signed [15:0] measured_left_i;
  logic signed [15:0] measured_right_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [16:0] drive_left_o;
  logic signed [16:0] drive_right_o;
  logic forward_left_o;
  logic forward_right_o;
  logic motors_enabled_o;
  logic watchdog_kick_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  drive_scoreboard scoreboard;
  bit idling = 1'b1;
  bit hold_off_req = 1'b0;

  differential_motor_pid_controller uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin : monitor
    cmd_beat_t taken;
    drive_result_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        taken.action = action_i;
        taken.kind = frame_kind_i;
        taken.arg_a = arg_a_i;
        taken.arg_b = arg_b_i;
        taken.meas_l = measured_left_i;
        taken.meas_r = measured_right_i;
        scoreboard.note_beat(taken);
      end
      if (out_valid_o && !out_stall_i) begin
        seen.drive_left = drive_left_o;
        seen.drive_right = drive_right_o;
        seen.forward_left = forward_left_o;
        seen.forward_right = forward_right_o;
        seen.motors_enabled = motors_enabled_o;
        seen.watchdog_kick = watchdog_kick_o;
        scoreboard.check_result(seen);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idling && ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin : run_limit
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic cmd_beat_t cmd_beat(logic [7:0] kind, logic [7:0] a, logic [7:0] b);
    cmd_beat_t c;
    c.action = 1'b0;
    c.kind = kind;
    c.arg_a = a;
    c.arg_b = b;
    c.meas_l = 16'($urandom);
    c.meas_r = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_beat_t tick_beat(logic signed [15:0] ml, logic signed [15:0] mr);
    cmd_beat_t c;
    c = cmd_beat(8'($urandom), 8'($urandom), 8'($urandom));
    c.action = 1'b1;
    c.meas_l = ml;
    c.meas_r = mr;
    return c;
  endfunction

  // Speed bytes lean toward zero, the midpoint, the clamp and the largest byte.
  function automatic logic [7:0] speed_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return PropMid;
      2: return PropClamp;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cmd_beat_t rand_beat();
    cmd_beat_t c;
    int unsigned pick;
    logic [7:0] key;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(1))
        c = tick_beat(16'($urandom), 16'($urandom));
      else
        c = tick_beat(16'($urandom_range(8191) - 4096), 16'($urandom_range(8191) - 4096));
    end else if (pick < 57) begin
      c = cmd_beat(FrameEnable, $urandom_range(1) ? 8'd0 : 8'($urandom), 8'($urandom));
    end else if (pick < 77) begin
      c = cmd_beat(FrameProp, speed_byte(), speed_byte());
    end else if (pick < 92) begin
      case ($urandom_range(4))
        0: key = KeyW;
        1: key = KeyS;
        2: key = KeyA;
        3: key = KeyD;
        default: key = 8'($urandom);
      endcase
      c = cmd_beat(FrameKey, key, 8'($urandom));
    end else begin
      c = cmd_beat(8'($urandom), 8'($urandom), 8'($urandom));
    end
    return c;
  endfunction

  task automatic send_beat(input cmd_beat_t c);
    @(negedge clk_i);
    while (idling && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= c.action;
    frame_kind_i <= c.kind;
    arg_a_i <= c.arg_a;
    arg_b_i <= c.arg_b;
    measured_left_i <= c.meas_l;
    measured_right_i <= c.meas_r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_beat(rand_beat());
  endtask

  // Stop offering beats until every expected result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (NumStages) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    scoreboard.configure(idx, val);
  endtask

  task automatic set_gains(input logic [7:0] kp_v, input logic [7:0] ki_v,
                           input logic [7:0] kd_v, input logic [11:0] max_v,
                           input logic [11:0] wsad_v, input logic [15:0] lim_v);
    settle();
    write_reg(CfgKp, 16'(kp_v));
    write_reg(CfgKi, 16'(ki_v));
    write_reg(CfgKd, 16'(kd_v));
    write_reg(CfgMaxSpeed, 16'(max_v));
    write_reg(CfgWsadSpeed, 16'(wsad_v));
    write_reg(CfgDriveLimit, lim_v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    scoreboard = new();
    in_valid_i = 1'b0;
    action_i = 1'b0;
    frame_kind_i = 8'd0;
    arg_a_i = 8'd0;
    arg_b_i = 8'd0;
    measured_left_i = 16'sd0;
    measured_right_i = 16'sd0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset gains.
    send_beat(tick_beat(16'sd0, 16'sd0));
    send_beat(cmd_beat(FrameEnable, 8'd1, 8'd0));
    send_beat(cmd_beat(FrameEnable, 8'd0, 8'hFF));
    send_beat(cmd_beat(FrameEnable, 8'hFF, 8'd0));
    send_beat(cmd_beat(FrameProp, 8'd0, 8'hFF));
    send_beat(tick_beat(-16'sd32768, 16'sd32767));
    send_beat(cmd_beat(FrameProp, PropMid, PropClamp));
    send_beat(cmd_beat(FrameProp, 8'd201, 8'd99));
    send_beat(tick_beat(16'sd32767, -16'sd32768));
    send_beat(cmd_beat(FrameKey, KeyW, 8'd0));
    send_beat(tick_beat(16'sd0, 16'sd0));
    send_beat(cmd_beat(FrameKey, KeyS, 8'hFF));
    send_beat(tick_beat(16'sd100, -16'sd100));
    send_beat(cmd_beat(FrameKey, KeyA, 8'd0));
    send_beat(cmd_beat(FrameKey, KeyD, 8'd0));
    send_beat(tick_beat(-16'sd1, 16'sd1));
    send_beat(cmd_beat(FrameKey, 8'h78, 8'd0));
    send_beat(tick_beat(16'sd0, 16'sd0));
    send_beat(cmd_beat(FrameKey, 8'h00, 8'd0));
    send_beat(cmd_beat(8'hFF, 8'hFF, 8'hFF));
    send_beat(cmd_beat(8'h00, 8'd0, 8'd0));
    send_beat(cmd_beat(FrameProp, 8'hFF, 8'd0));
    send_beat(tick_beat(-16'sd32768, -16'sd32768));
    send_beat(tick_beat(16'sd32767, 16'sd32767));

    set_gains(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 16'hFFFF);
    run_random(40);
    // The result side holds off while beats keep coming, so the pipeline fills.
    hold_off_req = 1'b1;
    run_random(160);

    set_gains(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 16'd0);
    run_random(120);

    idling = 1'b0;
    set_gains(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom));
    run_random(200);
    idling = 1'b1;

    set_gains(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom_range(2000)));
    run_random(100);
    settle();
    run_random(100);

    set_gains(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom));
    run_random(200);

    set_gains(KpReset, KiReset, KdReset, MaxSpeedReset, WsadSpeedReset, 16'd1);
    run_random(150);

    // Hold the largest error for a while, then reverse it.
    set_gains(8'd1, 8'd1, 8'd3, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_beat(cmd_beat(FrameProp, PropClamp, PropClamp));
    repeat (WindUpTicks) send_beat(tick_beat(-16'sd32768, -16'sd32768));
    send_beat(cmd_beat(FrameProp, 8'd0, 8'd0));
    repeat (WindDownTicks) send_beat(tick_beat(16'sd32767, 16'sd32767));
    run_random(120);

    settle();
    repeat (NumStages * 3) @(posedge clk_i);
    if (scoreboard.pending() != 0)
      $display("%0d expected result beats never arrived", scoreboard.pending());
    if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/dmpc_pkg.sv
src/dmpc_pid_lane.sv
src/differential_motor_pid_controller.sv
sim/tb_top.sv
